// ===== hw/rtl/pcl_pkg.sv =====
`timescale 1ns / 1ps

package pcl_pkg;

  localparam int COORD_WIDTH = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 2'd3;

  // request to the shared multiply / divide unit
  typedef struct packed {
    logic start;
    logic div;
  } mdu_req_t;

endpackage

// ===== hw/rtl/pcl_muldiv.sv =====
`timescale 1ns / 1ps

// Serial signed multiply, optionally followed by a truncating divide.
// Shift-add multiply, then a restoring divide of the 2*DW-bit product.
module pcl_muldiv #(
  parameter int DW = pcl_pkg::COORD_WIDTH + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pcl_pkg::mdu_req_t      req,
  input  logic signed [DW-1:0]   a,
  input  logic signed [DW-1:0]   b,
  input  logic signed [DW-1:0]   d,
  output logic                   done,
  output logic signed [2*DW:0]   prod,
  output logic signed [DW:0]     quot
);

  localparam int PW = 2 * DW;
  localparam int CW = $clog2(PW + 1);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV} ustate_t;

  ustate_t         st;
  logic [PW-1:0]   mcand;
  logic [DW-1:0]   mplier;
  logic [PW-1:0]   acc;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   den;
  logic [CW-1:0]   cnt;
  logic            neg;
  logic            dodiv;

  logic [DW-1:0]   mag_a, mag_b, mag_d;
  logic [PW-1:0]   acc_next;
  logic [DW:0]     rem_sh;
  logic            qbit;
  logic [DW:0]     rem_diff;
  logic [PW-1:0]   q_next;

  always_comb begin
    mag_a    = a[DW-1] ? -a : a;
    mag_b    = b[DW-1] ? -b : b;
    mag_d    = d[DW-1] ? -d : d;
    acc_next = mplier[0] ? acc + mcand : acc;
    rem_sh   = {rem, acc[PW-1]};
    rem_diff = rem_sh - {1'b0, den};
    qbit     = (rem_sh >= {1'b0, den});
    q_next   = {acc[PW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= ((st == U_MUL) && (cnt == CW'(1)) && !dodiv) ||
              ((st == U_DIV) && (cnt == CW'(1)));
      unique case (st)
        U_IDLE: begin
          if (req.start) begin
            mcand  <= {{DW{1'b0}}, mag_a};
            mplier <= mag_b;
            acc    <= '0;
            den    <= mag_d;
            cnt    <= CW'(DW);
            neg    <= a[DW-1] ^ b[DW-1] ^ (req.div & d[DW-1]);
            dodiv  <= req.div;
            st     <= U_MUL;
          end
        end
        U_MUL: begin
          acc    <= acc_next;
          mcand  <= {mcand[PW-2:0], 1'b0};
          mplier <= {1'b0, mplier[DW-1:1]};
          if (cnt == CW'(1)) begin
            if (dodiv) begin
              rem <= '0;
              cnt <= CW'(PW);
              st  <= U_DIV;
            end else begin
              prod <= neg ? -$signed({1'b0, acc_next}) : $signed({1'b0, acc_next});
              st   <= U_IDLE;
            end
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        U_DIV: begin
          acc <= q_next;
          rem <= qbit ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
          if (cnt == CW'(1)) begin
            quot <= neg ? -$signed(q_next[DW:0]) : $signed(q_next[DW:0]);
            st   <= U_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: st <= U_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/polyline_rect_clipper_unit.sv =====
`timescale 1ns / 1ps
// An item that only opens a line causes no result and is taken at once.
// Otherwise a clamped or inside point is emitted directly; a crossing uses a
// multiply and divide, a corner crossing two extra multiplies, all in the one
// serial multiply/divide unit; an item causes at most three results.
// Throughput: the input is held off until the last result of an item is on the output.
// Reset (synchronous, rst high): clip rectangle and vertex history cleared.

module polyline_rect_clipper_unit #(
  parameter int COORD_WIDTH = pcl_pkg::COORD_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // s_tdata: pt_x, pt_y (lowest bit up); s_tlast: final_vertex
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  input  logic                                   s_tlast,
  // m_tdata: out_x, out_y (lowest bit up); m_tuser: run_end; m_tlast: line_end
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
  output logic                                   m_tuser,
  output logic                                   m_tlast,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pcl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [COORD_WIDTH-1:0]                 cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;
  localparam int TDW = ((2 * W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    IDLE, CLASSIFY, CROSS, CMP1, CMP2, DIVS, DIVW, EMIT
  } state_t;

  state_t state;

  // clip rectangle
  logic signed [W-1:0] x_low, x_high, y_low, y_high;
  // vertex history
  logic signed [W-1:0] prev_x, prev_y, held_x, held_y;
  logic [1:0]          vertices_seen;
  // current job: vertex cv with neighbours pv and nv
  logic signed [W-1:0] cv_x, cv_y, pv_x, pv_y, nv_x, nv_y;
  logic                has_p, has_n, job2, line, pend_n;
  // crossing in progress: inside endpoint a, chosen edge
  logic signed [W-1:0] ax, ay, e_c;
  logic                e_vert;
  logic signed [2*DW:0] p1;
  // pending result
  logic signed [W-1:0] res_x, res_y;
  logic                res_end;

  // shared unit
  pcl_pkg::mdu_req_t    req;
  logic signed [DW-1:0] op_a, op_b, op_d;
  logic                 mdu_done;
  logic signed [2*DW:0] mdu_prod;
  logic signed [DW:0]   mdu_quot;

  pcl_muldiv #(.DW(DW)) u_mdu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (op_a),
    .b    (op_b),
    .d    (op_d),
    .done (mdu_done),
    .prod (mdu_prod),
    .quot (mdu_quot)
  );

  function automatic logic in_rect(input logic signed [W-1:0] x, input logic signed [W-1:0] y,
                                   input logic signed [W-1:0] xl, input logic signed [W-1:0] xh,
                                   input logic signed [W-1:0] yl, input logic signed [W-1:0] yh);
    return (x >= xl) && (x <= xh) && (y >= yl) && (y <= yh);
  endfunction

  function automatic logic signed [DW-1:0] dif(input logic signed [W-1:0] p,
                                               input logic signed [W-1:0] q);
    return {p[W-1], p} - {q[W-1], q};
  endfunction

  logic signed [W-1:0] in_x, in_y;
  logic                vin, pin, nin;
  logic                b_in_y, b_in_x, is_tr, is_tl, is_bl, horz;
  logic signed [W-1:0] cx, cy, cl_x, cl_y;
  logic signed [DW+1:0] sum_q;

  always_comb begin
    in_x   = s_tdata[W-1:0];
    in_y   = s_tdata[2*W-1:W];
    vin    = in_rect(cv_x, cv_y, x_low, x_high, y_low, y_high);
    pin    = has_p && in_rect(pv_x, pv_y, x_low, x_high, y_low, y_high);
    nin    = has_n && in_rect(nv_x, nv_y, x_low, x_high, y_low, y_high);
    b_in_y = (cv_y >= y_low) && (cv_y <= y_high);
    b_in_x = (cv_x >= x_low) && (cv_x <= x_high);
    is_tr  = (cv_x > x_high) && (cv_y > y_high);
    is_tl  = (cv_x < x_low) && (cv_y > y_high);
    is_bl  = (cv_x < x_low) && !(cv_y > y_high);
    cx     = (cv_x < x_low) ? x_low : x_high;
    cy     = (cv_y > y_high) ? y_high : y_low;
    // exact corner test: sign of p1 - p2
    priority if (is_tr) horz = (p1 > mdu_prod);
    else if (is_tl)     horz = (p1 < mdu_prod);
    else if (is_bl)     horz = !(p1 < mdu_prod);
    else                horz = (p1 < mdu_prod);
    // clamp: the later test wins
    cl_x = cv_x;
    if (cv_x > x_high) cl_x = x_high;
    if (cv_x < x_low)  cl_x = x_low;
    cl_y = cv_y;
    if (cv_y > y_high) cl_y = y_high;
    if (cv_y < y_low)  cl_y = y_low;
    sum_q = e_vert ? ({{3{ay[W-1]}}, ay} + {mdu_quot[DW], mdu_quot})
                   : ({{3{ax[W-1]}}, ax} + {mdu_quot[DW], mdu_quot});
  end

  // operands of the shared unit, chosen by state
  always_comb begin
    req  = '0;
    op_a = '0;
    op_b = '0;
    op_d = '0;
    unique case (state)
      CROSS: begin
        if (!b_in_y && !b_in_x) begin
          req.start = 1'b1;
          op_a      = dif(cx, ax);
          op_b      = dif(cv_y, ay);
        end
      end
      CMP1: begin
        if (mdu_done) begin
          req.start = 1'b1;
          op_a      = dif(cy, ay);
          op_b      = dif(cv_x, ax);
        end
      end
      DIVS: begin
        req.start = 1'b1;
        req.div   = 1'b1;
        if (e_vert) begin
          op_a = dif(cv_y, ay);
          op_b = dif(e_c, ax);
          op_d = dif(cv_x, ax);
        end else begin
          op_a = dif(cv_x, ax);
          op_b = dif(e_c, ay);
          op_d = dif(cv_y, ay);
        end
      end
      default: ;
    endcase
  end

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      x_low         <= '0;
      x_high        <= '0;
      y_low         <= '0;
      y_high        <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      held_x        <= '0;
      held_y        <= '0;
      vertices_seen <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // drop the shown result once taken, unless a new one replaces it
      if (m_tready && (state != EMIT)) m_tvalid <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_index)
          pcl_pkg::CFG_X_LOW:  x_low  <= cfg_data;
          pcl_pkg::CFG_X_HIGH: x_high <= cfg_data;
          pcl_pkg::CFG_Y_LOW:  y_low  <= cfg_data;
          pcl_pkg::CFG_Y_HIGH: y_high <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            if (vertices_seen == 2'd0) begin
              if (s_tlast) begin
                // one-point line: pass through unclipped
                res_x   <= in_x;
                res_y   <= in_y;
                res_end <= 1'b1;
                job2    <= 1'b0;
                line    <= 1'b1;
                pend_n  <= 1'b0;
                state   <= EMIT;
              end else begin
                held_x        <= in_x;
                held_y        <= in_y;
                vertices_seen <= 2'd1;
              end
            end else begin
              // clip the held vertex now that its successor is known
              cv_x          <= held_x;
              cv_y          <= held_y;
              pv_x          <= prev_x;
              pv_y          <= prev_y;
              has_p         <= (vertices_seen == 2'd2);
              nv_x          <= in_x;
              nv_y          <= in_y;
              has_n         <= 1'b1;
              job2          <= s_tlast;
              line          <= 1'b0;
              prev_x        <= held_x;
              prev_y        <= held_y;
              held_x        <= in_x;
              held_y        <= in_y;
              vertices_seen <= s_tlast ? 2'd0 : 2'd2;
              state         <= CLASSIFY;
            end
          end
        end
        CLASSIFY: begin
          priority if (vin) begin
            res_x   <= cv_x;
            res_y   <= cv_y;
            res_end <= 1'b1;
            pend_n  <= 1'b0;
            state   <= EMIT;
          end else if (!pin && !nin) begin
            res_x   <= cl_x;
            res_y   <= cl_y;
            res_end <= 1'b1;
            pend_n  <= 1'b0;
            state   <= EMIT;
          end else begin
            // predecessor crossing first
            ax     <= pin ? pv_x : nv_x;
            ay     <= pin ? pv_y : nv_y;
            pend_n <= pin && nin;
            state  <= CROSS;
          end
        end
        CROSS: begin
          priority if (b_in_y) begin
            e_vert <= 1'b1;
            e_c    <= (cv_x <= x_low) ? x_low : x_high;
            state  <= DIVS;
          end else if (b_in_x) begin
            e_vert <= 1'b0;
            e_c    <= (cv_y <= y_low) ? y_low : y_high;
            state  <= DIVS;
          end else begin
            state <= CMP1;
          end
        end
        CMP1: begin
          if (mdu_done) begin
            p1    <= mdu_prod;
            state <= CMP2;
          end
        end
        CMP2: begin
          if (mdu_done) begin
            e_vert <= !horz;
            e_c    <= horz ? cy : cx;
            state  <= DIVS;
          end
        end
        DIVS: state <= DIVW;
        DIVW: begin
          if (mdu_done) begin
            res_x   <= e_vert ? e_c : sum_q[W-1:0];
            res_y   <= e_vert ? sum_q[W-1:0] : e_c;
            res_end <= !pend_n;
            state   <= EMIT;
          end
        end
        EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= TDW'({res_y, res_x});
            m_tuser  <= res_end && !job2;
            m_tlast  <= line;
            if (pend_n) begin
              // now the crossing toward the successor
              ax     <= nv_x;
              ay     <= nv_y;
              pend_n <= 1'b0;
              state  <= CROSS;
            end else if (job2) begin
              // final vertex: its only neighbour is the old held vertex
              pv_x  <= cv_x;
              pv_y  <= cv_y;
              cv_x  <= nv_x;
              cv_y  <= nv_y;
              has_p <= 1'b1;
              has_n <= 1'b0;
              line  <= 1'b1;
              job2  <= 1'b0;
              state <= CLASSIFY;
            end else begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // the last point of a line always closes its run
  a_line_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("line end without run end");

  // the shared unit only finishes while the sequencer waits on it
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    mdu_done |-> (state == CMP1 || state == CMP2 || state == DIVW))
    else $error("unexpected completion from shared unit");

  // an item that causes results blocks the input
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tlast || vertices_seen != 2'd0) |=> !s_tready)
    else $error("input taken while results pending");

  // a result leaving the emit state is shown next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    state == EMIT && (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("result lost on emit");

endmodule
